@@ design/bmc_pkg.sv @@
// Package for the multi-click button classifier.
// Holds state and event codes, register indexes and reset defaults; no dependencies.
`timescale 1ns / 1ps

package bmc_pkg;

  localparam int unsigned TimerBitsDef = 16;
  localparam int unsigned CfgTimeW     = 16;
  localparam int unsigned CfgModeCntW  = 5;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned EventW       = 3;
  localparam int unsigned ModeW        = 4;

  localparam logic [CfgTimeW-1:0]    LongPressDef = 16'd1000;
  localparam logic [CfgTimeW-1:0]    ClickWinDef  = 16'd250;
  localparam logic [CfgTimeW-1:0]    HoldoffDef   = 16'd1000;
  localparam logic [CfgModeCntW-1:0] ModeCountDef = 5'd6;
  localparam logic [CfgModeCntW-1:0] ModeCountMax = 5'd16;

  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClickWin  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHoldoff   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgModeCount = 2'd3;

  typedef enum logic [2:0] {
    StIdle          = 3'd0,
    StPressed       = 3'd1,
    StWaitDouble    = 3'd2,
    StWaitTriple    = 3'd3,
    StTripleTimeout = 3'd4,
    StLong          = 3'd5,
    StWaitRelease   = 3'd6
  } click_state_e;

  typedef enum logic [EventW-1:0] {
    EvNone = 3'd0,
    EvMute = 3'd1,
    EvNext = 3'd2,
    EvPrev = 3'd3,
    EvMode = 3'd4
  } event_e;

  typedef struct packed {
    logic [CfgTimeW-1:0]    long_press;
    logic [CfgTimeW-1:0]    click_win;
    logic [CfgTimeW-1:0]    holdoff;
    logic [CfgModeCntW-1:0] mode_count;
  } cfg_t;

endpackage

@@ design/button_multi_click_classifier.sv @@
// Top level of the multi-click button classifier: configuration registers,
// result register and handshakes around bmc_fsm. Depends on bmc_pkg and bmc_fsm.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / pressed_i): one request per
//   millisecond tick carrying the button level. Output channel (out_valid_o /
//   out_ready_i / event_res_o / mode_o): exactly one result per request,
//   event 0 none, 1 mute, 2 next, 3 previous, 4 mode change, and the display
//   mode after that tick.
//   The result appears in the result register in the cycle after the request
//   is accepted. Throughput: one request per cycle unless the receiver stalls;
//   the classifier state, both timers and the display mode update together.
//   Stall: in_ready_o is high while the result register is empty or being
//   taken in the same cycle, so a waiting result never blocks the next
//   request unless the receiver holds out_ready_i low; then the result holds.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 long press, 1 click window, 2 mute hold-off, 3 mode count) at once;
//   write only while the block is idle.
//   Reset: rst_ni clears the classifier to idle, both timers and the mode to
//   zero, empties the result register and loads the default configuration.
module button_multi_click_classifier #(
  parameter int unsigned TIMER_BITS = bmc_pkg::TimerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bmc_pkg::CfgTimeW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          pressed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bmc_pkg::EventW-1:0]    event_res_o,
  output logic [bmc_pkg::ModeW-1:0]     mode_o
);

  bmc_pkg::cfg_t             cfg_q;
  logic                      in_fire;
  logic                      out_valid_q;
  logic [bmc_pkg::EventW-1:0] event_q;
  logic [bmc_pkg::ModeW-1:0]  mode_q;
  bmc_pkg::click_state_e     fsm_state;
  bmc_pkg::event_e           fsm_event;
  logic [bmc_pkg::ModeW-1:0]  fsm_mode;

  // Configuration registers: plain indexed writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press <= bmc_pkg::LongPressDef;
      cfg_q.click_win  <= bmc_pkg::ClickWinDef;
      cfg_q.holdoff    <= bmc_pkg::HoldoffDef;
      cfg_q.mode_count <= bmc_pkg::ModeCountDef;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmc_pkg::CfgLongPress: cfg_q.long_press <= cfg_data_i;
        bmc_pkg::CfgClickWin:  cfg_q.click_win  <= cfg_data_i;
        bmc_pkg::CfgHoldoff:   cfg_q.holdoff    <= cfg_data_i;
        bmc_pkg::CfgModeCount:
          cfg_q.mode_count <= cfg_data_i[bmc_pkg::CfgModeCntW-1:0];
        default: ;
      endcase
    end
  end

  // Accept a request whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  bmc_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .pressed_i(pressed_i),
    .cfg_i    (cfg_q),
    .state_o  (fsm_state),
    .event_o  (fsm_event),
    .mode_o   (fsm_mode)
  );

  // Result register: valid bit under reset, payload loaded on accept only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= fsm_event;
      mode_q  <= fsm_mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign mode_o      = mode_q;

  // Every accepted request leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request produced no result");

  // A tick taken in the long-press state reports a mode change
  a_long_reports_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (fsm_state == bmc_pkg::StLong) |=>
      out_valid_o && (event_res_o == bmc_pkg::EvMode))
    else $error("long press did not report a mode change");

  // Mode only moves on a mode-change result
  a_mode_moves_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (fsm_event != bmc_pkg::EvMode) |-> (fsm_mode == u_fsm.mode_q))
    else $error("display mode changed without a mode event");

endmodule

@@ design/bmc_fsm.sv @@
// Click classifier state machine with its two saturating timers and display mode.
// Depends on bmc_pkg.
`timescale 1ns / 1ps

module bmc_fsm #(
  parameter int unsigned TIMER_BITS = bmc_pkg::TimerBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      pressed_i,
  input  bmc_pkg::cfg_t             cfg_i,
  output bmc_pkg::click_state_e     state_o,
  output bmc_pkg::event_e           event_o,
  output logic [bmc_pkg::ModeW-1:0] mode_o
);

  localparam int unsigned CmpW =
    (TIMER_BITS > bmc_pkg::CfgTimeW) ? TIMER_BITS : bmc_pkg::CfgTimeW;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  bmc_pkg::click_state_e state_q, state_d;
  logic [TIMER_BITS-1:0]    elapsed_q, elapsed_d, elapsed_inc;
  logic [TIMER_BITS-1:0]    since_q, since_d, since_inc;
  logic [bmc_pkg::ModeW-1:0] mode_q, mode_d;
  bmc_pkg::event_e          event_d;

  logic [CmpW-1:0] elapsed_x, win_x, long_x, hold_x, since_x;
  logic            lt_win, gt_win, gt_long, gt_hold;
  logic [bmc_pkg::CfgModeCntW-1:0] count_eff, mode_inc;

  // Advance both timers first, saturating at all ones
  assign elapsed_inc = (elapsed_q == TimerMax) ? elapsed_q : elapsed_q + 1'b1;
  assign since_inc   = (since_q == TimerMax) ? since_q : since_q + 1'b1;

  assign elapsed_x = CmpW'(elapsed_inc);
  assign since_x   = CmpW'(since_inc);
  assign win_x     = CmpW'(cfg_i.click_win);
  assign long_x    = CmpW'(cfg_i.long_press);
  assign hold_x    = CmpW'(cfg_i.holdoff);

  assign lt_win  = elapsed_x < win_x;
  assign gt_win  = elapsed_x > win_x;
  assign gt_long = elapsed_x > long_x;
  assign gt_hold = since_x > hold_x;

  // Clamp mode count into one to sixteen
  assign count_eff = (cfg_i.mode_count == '0) ? bmc_pkg::CfgModeCntW'(1) :
                     (cfg_i.mode_count > bmc_pkg::ModeCountMax) ? bmc_pkg::ModeCountMax :
                     cfg_i.mode_count;
  assign mode_inc  = bmc_pkg::CfgModeCntW'(mode_q) + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmc_pkg::StIdle: begin
        if (pressed_i) state_d = bmc_pkg::StPressed;
      end
      bmc_pkg::StPressed: begin
        if (!pressed_i)   state_d = bmc_pkg::StWaitDouble;
        else if (gt_long) state_d = bmc_pkg::StLong;
      end
      bmc_pkg::StLong: state_d = bmc_pkg::StIdle;
      bmc_pkg::StWaitDouble: begin
        if (pressed_i && lt_win)                  state_d = bmc_pkg::StWaitTriple;
        else if (!pressed_i && gt_hold && gt_win) state_d = bmc_pkg::StWaitRelease;
      end
      bmc_pkg::StWaitTriple: begin
        if (!pressed_i && lt_win) state_d = bmc_pkg::StTripleTimeout;
      end
      bmc_pkg::StTripleTimeout: begin
        if ((pressed_i && lt_win) || gt_win) state_d = bmc_pkg::StWaitRelease;
      end
      bmc_pkg::StWaitRelease: begin
        if (!pressed_i) state_d = bmc_pkg::StIdle;
      end
      default: state_d = bmc_pkg::StIdle;
    endcase
  end

  always_comb begin
    event_d   = bmc_pkg::EvNone;
    elapsed_d = elapsed_inc;
    since_d   = since_inc;
    mode_d    = mode_q;
    unique case (state_q)
      bmc_pkg::StIdle: begin
        if (pressed_i) elapsed_d = '0;
      end
      bmc_pkg::StLong: begin
        mode_d  = (mode_inc >= count_eff) ? '0 : mode_inc[bmc_pkg::ModeW-1:0];
        event_d = bmc_pkg::EvMode;
        since_d = '0;
      end
      bmc_pkg::StWaitDouble: begin
        if (pressed_i && lt_win)                  elapsed_d = '0;
        else if (!pressed_i && gt_hold && gt_win) event_d   = bmc_pkg::EvMute;
      end
      bmc_pkg::StTripleTimeout: begin
        if (pressed_i && lt_win) event_d = bmc_pkg::EvPrev;
        else if (gt_win)         event_d = bmc_pkg::EvNext;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bmc_pkg::StIdle;
      elapsed_q <= '0;
      since_q   <= '0;
      mode_q    <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      since_q   <= since_d;
      mode_q    <= mode_d;
    end
  end

  assign state_o = state_q;
  assign event_o = event_d;
  assign mode_o  = mode_d;

endmodule
